[design/elliptic_arc_to_cubic_bezier_assert.svh]
// ----------------------------------------------------------------------------
// Elliptic arc converter assertion macros
// Shorthand for clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ELLIPTIC_ARC_TO_CUBIC_BEZIER_ASSERT_SVH
`define ELLIPTIC_ARC_TO_CUBIC_BEZIER_ASSERT_SVH

// same-cycle implication
`define EACB_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eacb assertion failed");

// next-cycle implication
`define EACB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("eacb assertion failed");

`endif

[design/eacb_pkg.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter package
// Shared constants, command/status types and helper functions.
// ----------------------------------------------------------------------------
package eacb_pkg;

  // angle constants, Q7.24
  localparam logic signed [33:0] TwoPiQ24  = 34'sd105414357;
  localparam logic signed [33:0] HalfPiQ24 = 34'sd26353589;
  localparam logic signed [33:0] Pi2Q24    = 34'sd52707178;
  localparam logic signed [33:0] Pi3Q24    = 34'sd79060767;
  localparam logic signed [33:0] EpsQ24    = 34'sd16777;

  // angle constants, Q2.30
  localparam logic [39:0]        TwoPiQ30  = 40'd6746518852;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  // reciprocal of three, exact for 32-bit dividends with a 33-bit shift
  localparam logic signed [35:0] Div3Recip = 36'sh0AAAAAAAB;

  // record kinds
  localparam logic [1:0] KindMove  = 2'd0;
  localparam logic [1:0] KindLine  = 2'd1;
  localparam logic [1:0] KindFull  = 2'd2;
  localparam logic [1:0] KindCubic = 2'd3;

  // configuration register indexes
  localparam logic CfgOffsetX = 1'b0;
  localparam logic CfgOffsetY = 1'b1;

  typedef enum logic [3:0] {
    MopDiv3, MopNrxc, MopNrxs, MopNryc, MopNrys, MopM1, MopM2, MopM3, MopM4
  } mul_op_e;

  typedef enum logic [1:0] {EmitStart, EmitCubic, EmitFull} emit_sel_e;

  typedef enum logic {AngDelta, AngRun} ang_sel_e;

  typedef struct packed {
    logic      load;
    logic      classify;
    logic      delta;
    logic      mul_go;
    logic      mul_wb;
    mul_op_e   mul_op;
    logic      cord_go;
    ang_sel_e  cord_sel;
    logic      div_go;
    logic      emit;
    emit_sel_e emit_sel;
    logic      last;
    logic      ang_step;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       segs3;
    logic [2:0] segs;
    logic       cord_done;
    logic       div_done;
    logic       out_free;
  } stat_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837830;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021688;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd31: v = 32'd1;
      default: v = 32'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[design/eacb_cordic.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter CORDIC unit
// Reduces a Q2.30 angle modulo 2pi, folds it to +-pi/2, then rotates.
// ----------------------------------------------------------------------------
module eacb_cordic #(
  parameter int STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [39:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);
  import eacb_pkg::*;

  localparam int IW = $clog2(STEPS);
  localparam logic signed [35:0] TwoPiS = 36'(TwoPiQ30);

  typedef enum logic [2:0] {CIdle, CRed, CFold, CHalf, CRot} state_e;

  state_e             state_q;
  logic [2:0]         j_q;
  logic [IW-1:0]      i_q;
  logic               done_q, neg_q, flip_q;
  logic [39:0]        mag_q;
  logic signed [35:0] r_q;
  logic signed [33:0] x_q, y_q;

  logic [39:0]        red_step;
  logic signed [35:0] r0, rf, rh, at;
  logic signed [33:0] sx, sy;
  logic               hflip;

  // reduction step: subtract 2pi << j when it fits
  assign red_step = TwoPiQ30 << j_q;

  // fold into +-pi
  always_comb begin
    r0 = $signed(mag_q[35:0]);
    rf = neg_q ? -r0 : r0;
    if (rf > PiQ30) rf = rf - TwoPiS;
    if (rf < -PiQ30) rf = rf + TwoPiS;
  end

  // fold into +-pi/2, flipping the result
  always_comb begin
    rh    = r_q;
    hflip = 1'b0;
    if (r_q > HalfPiQ30) begin
      rh    = r_q - PiQ30;
      hflip = 1'b1;
    end else if (r_q < -HalfPiQ30) begin
      rh    = r_q + PiQ30;
      hflip = 1'b1;
    end
  end

  assign sx = x_q >>> i_q;
  assign sy = y_q >>> i_q;
  assign at = $signed(36'(atan_q30(5'(i_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      j_q     <= '0;
      i_q     <= '0;
      done_q  <= 1'b0;
      neg_q   <= 1'b0;
      flip_q  <= 1'b0;
      mag_q   <= '0;
      r_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        CIdle: begin
          if (start_i) begin
            neg_q   <= angle_i[39];
            mag_q   <= angle_i[39] ? 40'(-angle_i) : 40'(angle_i);
            j_q     <= 3'd6;
            state_q <= CRed;
          end
        end
        CRed: begin
          if (mag_q >= red_step) mag_q <= mag_q - red_step;
          if (j_q == 3'd0) state_q <= CFold;
          else j_q <= j_q - 3'd1;
        end
        CFold: begin
          r_q     <= rf;
          state_q <= CHalf;
        end
        CHalf: begin
          r_q     <= rh;
          flip_q  <= hflip;
          x_q     <= GainQ30;
          y_q     <= '0;
          i_q     <= '0;
          state_q <= CRot;
        end
        CRot: begin
          if (r_q >= 0) begin
            x_q <= x_q - sy;
            y_q <= y_q + sx;
            r_q <= r_q - at;
          end else begin
            x_q <= x_q + sy;
            y_q <= y_q - sx;
            r_q <= r_q + at;
          end
          if (i_q == IW'(STEPS - 1)) begin
            done_q  <= 1'b1;
            state_q <= CIdle;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        default: state_q <= CIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

[design/eacb_div.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eacb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [35:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] acc_q;
  logic [35:0] rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [36:0] rem_sh, rem_nx;
  logic        ge;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_q, acc_q[63]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= {acc_q[62:0], ge};
        rem_q <= rem_nx[35:0];
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

[design/eacb_dp.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter datapath
// Arc registers, shared multiplier, CORDIC, divider and the output register.
// ----------------------------------------------------------------------------
module eacb_dp #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eacb_pkg::cmd_t     cmd_i,
  output eacb_pkg::stat_t    stat_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] radius_x_i,
  input  logic signed [31:0] radius_y_i,
  input  logic signed [31:0] start_angle_i,
  input  logic signed [31:0] end_angle_i,
  input  logic               counter_clockwise_i,
  input  logic               path_empty_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         record_kind_o,
  output logic signed [31:0] first_x_o,
  output logic signed [31:0] first_y_o,
  output logic signed [31:0] second_x_o,
  output logic signed [31:0] second_y_o,
  output logic signed [31:0] end_x_o,
  output logic signed [31:0] end_y_o,
  output logic               last_record_o
);
  import eacb_pkg::*;

  logic signed [31:0] offx_q, offy_q;
  logic               out_valid_q;

  logic signed [33:0] pcx_q, pcy_q, ang_q, sw_q;
  logic signed [31:0] rx_q, ry_q;
  logic signed [32:0] sweep_q;
  logic               ccw_q, empty_q, neg_q, t_neg_q;
  logic [26:0]        mag_q;
  logic [2:0]         segs_q;
  logic signed [27:0] delta_q;
  logic signed [71:0] prod_q;
  logic signed [35:0] n_rxc_q, n_rxs_q, n_ryc_q, n_rys_q;
  logic signed [35:0] p_rxc_q, p_rxs_q, p_ryc_q, p_rys_q;
  logic signed [35:0] m1_q, m2_q, m3_q, m4_q;

  logic [1:0]         kind_q;
  logic signed [31:0] fx_q, fy_q, sx_q, sy_q, ex_q, ey_q;
  logic               last_q;

  // ---- classification of the sweep ----
  logic signed [33:0] sweep_w, sweep_abs, wrap, sw_abs;
  logic [26:0]        mag_c, shq;
  logic [2:0]         segs_c;
  logic signed [27:0] shd;

  assign sweep_w   = 34'(sweep_q);
  assign sweep_abs = sweep_w[33] ? -sweep_w : sweep_w;

  always_comb begin
    wrap = sweep_w;
    if (!ccw_q && sweep_w < 0) wrap = wrap + TwoPiQ24;
    if (ccw_q && sweep_w > 0) wrap = wrap - TwoPiQ24;
    if (wrap > TwoPiQ24) wrap = TwoPiQ24;
    else if (wrap < -TwoPiQ24) wrap = -TwoPiQ24;
  end

  assign sw_abs = sw_q[33] ? -sw_q : sw_q;
  assign mag_c  = sw_abs[26:0];

  // segment count is ceil(|sweep| / (pi/2)), at least one
  always_comb begin
    if (sw_abs <= HalfPiQ24) segs_c = 3'd1;
    else if (sw_abs <= Pi2Q24) segs_c = 3'd2;
    else if (sw_abs <= Pi3Q24) segs_c = 3'd3;
    else segs_c = 3'd4;
  end

  // power-of-two counts divide by shifting; three goes through the multiplier
  always_comb begin
    priority case (segs_c)
      3'd2:    shq = mag_c >> 1;
      3'd4:    shq = mag_c >> 2;
      default: shq = mag_c;
    endcase
    shd = sw_q[33] ? -$signed({1'b0, shq}) : $signed({1'b0, shq});
  end

  // ---- CORDIC and divider ----
  logic signed [39:0] cord_ang;
  logic signed [33:0] cs, cc, ts_abs, tc_c;
  logic               cord_done, div_done;
  logic [63:0]        div_num, quo;
  logic [35:0]        div_den;
  logic signed [35:0] tq, t_c;

  assign cord_ang = (cmd_i.cord_sel == AngDelta) ? (40'(delta_q) <<< 4)
                                                 : $signed({ang_q, 6'b0});

  eacb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cord_go),
    .angle_i (cord_ang),
    .done_o  (cord_done),
    .sin_o   (cs),
    .cos_o   (cc)
  );

  // handle factor t = 4 sin / (3 cos), magnitude divided, sign restored
  assign ts_abs  = cs[33] ? -cs : cs;
  assign tc_c    = (cc <= 0) ? 34'sd1 : cc;
  assign div_num = {ts_abs[31:0], 32'd0};
  assign div_den = 36'(tc_c) + (36'(tc_c) << 1);

  eacb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign tq  = $signed(quo[35:0]);
  assign t_c = t_neg_q ? -tq : tq;

  // ---- shared multiplier ----
  logic signed [35:0] op_a, op_b, mres;
  logic signed [71:0] rnd;
  logic signed [27:0] d3;

  always_comb begin
    unique case (cmd_i.mul_op)
      MopDiv3: begin op_a = $signed({9'd0, mag_q}); op_b = Div3Recip; end
      MopNrxc: begin op_a = 36'(rx_q); op_b = 36'(cc); end
      MopNrxs: begin op_a = 36'(rx_q); op_b = 36'(cs); end
      MopNryc: begin op_a = 36'(ry_q); op_b = 36'(cc); end
      MopNrys: begin op_a = 36'(ry_q); op_b = 36'(cs); end
      MopM1:   begin op_a = p_rxs_q;   op_b = t_c; end
      MopM2:   begin op_a = p_ryc_q;   op_b = t_c; end
      MopM3:   begin op_a = n_rxs_q;   op_b = t_c; end
      MopM4:   begin op_a = n_ryc_q;   op_b = t_c; end
      default: begin op_a = '0;        op_b = '0; end
    endcase
  end

  // Q2.30 product, rounded half up
  assign rnd  = prod_q + 72'sd536870912;
  assign mres = rnd[65:30];
  assign d3   = $signed({1'b0, prod_q[59:33]});

  // ---- record assembly ----
  logic signed [39:0] pcx_e, pcy_e, ax, ay;
  logic [1:0]         kind_c;
  logic signed [31:0] fx_c, fy_c, sx_c, sy_c, ex_c, ey_c;

  assign pcx_e = 40'(pcx_q);
  assign pcy_e = 40'(pcy_q);
  assign ax    = pcx_e + 40'(n_rxc_q);
  assign ay    = pcy_e + 40'(n_rys_q);

  always_comb begin
    unique case (cmd_i.emit_sel)
      EmitStart: begin
        kind_c = empty_q ? KindMove : KindLine;
        fx_c = sat32(ax);
        fy_c = sat32(ay);
        sx_c = '0;
        sy_c = '0;
        ex_c = '0;
        ey_c = '0;
      end
      EmitCubic: begin
        kind_c = KindCubic;
        fx_c = sat32(pcx_e + 40'(p_rxc_q) - 40'(m1_q));
        fy_c = sat32(pcy_e + 40'(p_rys_q) + 40'(m2_q));
        sx_c = sat32(ax + 40'(m3_q));
        sy_c = sat32(ay - 40'(m4_q));
        ex_c = sat32(ax);
        ey_c = sat32(ay);
      end
      default: begin
        kind_c = KindFull;
        fx_c = sat32(pcx_e);
        fy_c = sat32(pcy_e);
        sx_c = rx_q;
        sy_c = ry_q;
        ex_c = '0;
        ey_c = '0;
      end
    endcase
  end

  // ---- control registers: offsets and output valid ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q      <= '0;
      offy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgOffsetX: offx_q <= $signed(cfg_wdata_i);
          CfgOffsetY: offy_q <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pcx_q   <= 34'(center_x_i) + 34'(offx_q);
      pcy_q   <= 34'(center_y_i) + 34'(offy_q);
      rx_q    <= radius_x_i;
      ry_q    <= radius_y_i;
      sweep_q <= 33'(end_angle_i) - 33'(start_angle_i);
      ang_q   <= 34'(start_angle_i);
      ccw_q   <= counter_clockwise_i;
      empty_q <= path_empty_i;
    end
    if (cmd_i.classify) sw_q <= wrap;
    if (cmd_i.delta) begin
      mag_q   <= mag_c;
      segs_q  <= segs_c;
      neg_q   <= sw_q[33];
      delta_q <= shd;
    end
    if (cmd_i.mul_go) prod_q <= op_a * op_b;
    if (cmd_i.mul_wb) begin
      unique case (cmd_i.mul_op)
        MopDiv3: delta_q <= neg_q ? -d3 : d3;
        MopNrxc: n_rxc_q <= mres;
        MopNrxs: n_rxs_q <= mres;
        MopNryc: n_ryc_q <= mres;
        MopNrys: n_rys_q <= mres;
        MopM1:   m1_q    <= mres;
        MopM2:   m2_q    <= mres;
        MopM3:   m3_q    <= mres;
        MopM4:   m4_q    <= mres;
        default: ;
      endcase
    end
    if (cmd_i.div_go) t_neg_q <= cs[33];
    if (cmd_i.ang_step) ang_q <= ang_q + 34'(delta_q);
    if (cmd_i.emit) begin
      kind_q  <= kind_c;
      fx_q    <= fx_c;
      fy_q    <= fy_c;
      sx_q    <= sx_c;
      sy_q    <= sy_c;
      ex_q    <= ex_c;
      ey_q    <= ey_c;
      last_q  <= cmd_i.last;
      // the end angle of this record starts the next segment
      p_rxc_q <= n_rxc_q;
      p_rxs_q <= n_rxs_q;
      p_ryc_q <= n_ryc_q;
      p_rys_q <= n_rys_q;
    end
  end

  // ---- status ----
  always_comb begin
    stat_o.full      = sweep_abs >= (TwoPiQ24 - EpsQ24);
    stat_o.segs3     = segs_c == 3'd3;
    stat_o.segs      = segs_q;
    stat_o.cord_done = cord_done;
    stat_o.div_done  = div_done;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = kind_q;
  assign first_x_o     = fx_q;
  assign first_y_o     = fy_q;
  assign second_x_o    = sx_q;
  assign second_y_o    = sy_q;
  assign end_x_o       = ex_q;
  assign end_y_o       = ey_q;
  assign last_record_o = last_q;

endmodule

[design/eacb_ctrl.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter controller
// Sequences classification, trig passes, multiplies and record output.
// ----------------------------------------------------------------------------
module eacb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  eacb_pkg::stat_t stat_i,
  output eacb_pkg::cmd_t  cmd_o
);
  import eacb_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SClass, SFull, SDelta, SMul, SMulWb, STCord, STWait,
    STDiv, STDWait, SACord, SAWait, SEmit, SStep
  } state_e;

  state_e     state_q;
  mul_op_e    op_q;
  logic       seg_phase_q;
  logic [1:0] cnt_q;
  logic       last_c;

  assign last_c = seg_phase_q && ({1'b0, cnt_q} == stat_i.segs - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      op_q        <= MopDiv3;
      seg_phase_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      unique case (state_q)
        SIdle:   if (in_valid_i) state_q <= SClass;
        SClass:  state_q <= stat_i.full ? SFull : SDelta;
        SFull:   if (stat_i.out_free) state_q <= SIdle;
        SDelta: begin
          if (stat_i.segs3) begin
            op_q    <= MopDiv3;
            state_q <= SMul;
          end else begin
            state_q <= STCord;
          end
        end
        SMul:    state_q <= SMulWb;
        SMulWb: begin
          unique case (op_q)
            MopDiv3: state_q <= STCord;
            MopNrys: begin
              if (seg_phase_q) begin
                op_q    <= MopM1;
                state_q <= SMul;
              end else begin
                state_q <= SEmit;
              end
            end
            MopM4:   state_q <= SEmit;
            default: begin
              op_q    <= mul_op_e'(op_q + 4'd1);
              state_q <= SMul;
            end
          endcase
        end
        STCord:  state_q <= STWait;
        STWait:  if (stat_i.cord_done) state_q <= STDiv;
        STDiv:   state_q <= STDWait;
        STDWait: begin
          if (stat_i.div_done) begin
            seg_phase_q <= 1'b0;
            state_q     <= SACord;
          end
        end
        SACord:  state_q <= SAWait;
        SAWait: begin
          if (stat_i.cord_done) begin
            op_q    <= MopNrxc;
            state_q <= SMul;
          end
        end
        SEmit: begin
          if (stat_i.out_free) begin
            if (!seg_phase_q) begin
              seg_phase_q <= 1'b1;
              cnt_q       <= '0;
              state_q     <= SStep;
            end else if (last_c) begin
              state_q <= SIdle;
            end else begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= SStep;
            end
          end
        end
        SStep:   state_q <= SACord;
        default: state_q <= SIdle;
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_op   = op_q;
    cmd_o.cord_sel = (state_q == STCord) ? AngDelta : AngRun;
    cmd_o.emit_sel = (state_q == SFull) ? EmitFull
                   : (seg_phase_q ? EmitCubic : EmitStart);
    cmd_o.last     = (state_q == SFull) || last_c;
    cmd_o.load     = (state_q == SIdle) && in_valid_i;
    cmd_o.classify = state_q == SClass;
    cmd_o.delta    = state_q == SDelta;
    cmd_o.mul_go   = state_q == SMul;
    cmd_o.mul_wb   = state_q == SMulWb;
    cmd_o.cord_go  = (state_q == STCord) || (state_q == SACord);
    cmd_o.div_go   = state_q == STDiv;
    cmd_o.emit     = ((state_q == SEmit) || (state_q == SFull)) && stat_i.out_free;
    cmd_o.ang_step = state_q == SStep;
  end

  assign in_ready_o = state_q == SIdle;

endmodule

[design/elliptic_arc_to_cubic_bezier.sv]
// ----------------------------------------------------------------------------
// Elliptic arc to cubic Bezier converter
// Turns one axis-aligned elliptic arc word into up to five path records.
// ----------------------------------------------------------------------------
// One arc word is taken at a time. A full-ellipse arc gives one record,
// emitted from the full-ellipse state after classification. Any other arc of
// n segments (1 to 4) takes one CORDIC pass per angle (the handle angle, the
// start angle and each segment end) on the single shared rotator, one run of
// the handle-factor divider, and its multiplies on the one shared multiplier,
// with one more multiply when n is three. The output register holds each
// record until it is taken; the next arc word is taken while the final record
// still waits.
module elliptic_arc_to_cubic_bezier #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] radius_x_i,
  input  logic signed [31:0] radius_y_i,
  input  logic signed [31:0] start_angle_i,
  input  logic signed [31:0] end_angle_i,
  input  logic               counter_clockwise_i,
  input  logic               path_empty_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         record_kind_o,
  output logic signed [31:0] first_x_o,
  output logic signed [31:0] first_y_o,
  output logic signed [31:0] second_x_o,
  output logic signed [31:0] second_y_o,
  output logic signed [31:0] end_x_o,
  output logic signed [31:0] end_y_o,
  output logic               last_record_o
);
  import eacb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  eacb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and output register
  eacb_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .center_x_i          (center_x_i),
    .center_y_i          (center_y_i),
    .radius_x_i          (radius_x_i),
    .radius_y_i          (radius_y_i),
    .start_angle_i       (start_angle_i),
    .end_angle_i         (end_angle_i),
    .counter_clockwise_i (counter_clockwise_i),
    .path_empty_i        (path_empty_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .record_kind_o       (record_kind_o),
    .first_x_o           (first_x_o),
    .first_y_o           (first_y_o),
    .second_x_o          (second_x_o),
    .second_y_o          (second_y_o),
    .end_x_o             (end_x_o),
    .end_y_o             (end_y_o),
    .last_record_o       (last_record_o)
  );

endmodule

[design/eacb_checker.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter port checker
// Watches the output records at the top-level ports.
// ----------------------------------------------------------------------------
`include "elliptic_arc_to_cubic_bezier_assert.svh"

module eacb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         record_kind_o,
  input logic signed [31:0] first_x_o,
  input logic signed [31:0] second_x_o,
  input logic signed [31:0] second_y_o,
  input logic signed [31:0] end_x_o,
  input logic signed [31:0] end_y_o,
  input logic               last_record_o
);
  import eacb_pkg::*;

  // a stalled record word holds
  `EACB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(record_kind_o) && $stable(first_x_o) && $stable(last_record_o))

  // a full ellipse is always the only record of its arc
  `EACB_ASSERT(a_full_last, out_valid_o && (record_kind_o == KindFull), last_record_o)

  // move and line open an arc and carry no second point
  `EACB_ASSERT(a_start_shape, out_valid_o && ((record_kind_o == KindMove) || (record_kind_o == KindLine)), !last_record_o && (second_x_o == 0) && (second_y_o == 0))

  // only cubics carry an end point
  `EACB_ASSERT(a_end_zero, out_valid_o && (record_kind_o != KindCubic), (end_x_o == 0) && (end_y_o == 0))

endmodule

bind elliptic_arc_to_cubic_bezier eacb_checker u_eacb_checker (.*);

[tb/elliptic_arc_to_cubic_bezier_tb.sv]
// ----------------------------------------------------------------------------
// Elliptic arc converter testbench
// Drives arc words through valid/ready with random gaps and stalls, predicts
// the path records in fixed point alongside, and compares every record.
// ----------------------------------------------------------------------------
module elliptic_arc_to_cubic_bezier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eacb_pkg::*;

  localparam int Steps = 24;
  localparam int MaxCycles = 2_000_000;
  localparam longint TwoPi24 = 64'sd105414357;
  localparam longint HalfPi24 = 64'sd26353589;
  localparam longint Eps24 = 64'sd16777;
  localparam longint Pi30 = 64'sd3373259426;
  localparam longint TwoPi30 = 64'sd6746518852;
  localparam longint HalfPi30 = 64'sd1686629713;
  localparam longint Gain30 = 64'sd652032874;

  typedef struct {
    logic signed [31:0] cx, cy, rx, ry, a0, a1;
    logic ccw, empty;
  } arc_t;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] fx, fy, sx, sy, ex, ey;
    logic last;
  } rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] center_x_i = '0, center_y_i = '0, radius_x_i = '0, radius_y_i = '0;
  logic signed [31:0] start_angle_i = '0, end_angle_i = '0;
  logic counter_clockwise_i = 1'b0, path_empty_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] record_kind_o;
  logic signed [31:0] first_x_o, first_y_o, second_x_o, second_y_o, end_x_o, end_y_o;
  logic last_record_o;

  elliptic_arc_to_cubic_bezier #(.CORDIC_STEPS(Steps)) dut (.*);

  always #6 clk_i = ~clk_i;

  arc_t pending_arcs[$];
  rec_t expected_recs[$];
  longint off_x = 0, off_y = 0;
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit driver_paused = 1'b0;

  // arctangent table, Q2.30
  function automatic longint atan_step(int i);
    longint tbl[10] = '{843314857, 497837830, 263043837, 133525159, 67021688,
                        33543515, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i == 31) return 1;
    return longint'(1) << (30 - i);
  endfunction

  // CORDIC sine and cosine of a Q2.30 angle of any size
  task automatic rotate(input longint ang, output longint s, output longint c);
    longint r, x, y, xn;
    bit flip;
    r = ang % TwoPi30;
    flip = 0;
    x = Gain30;
    y = 0;
    if (r > Pi30) r -= TwoPi30;
    if (r < -Pi30) r += TwoPi30;
    if (r > HalfPi30) begin r -= Pi30; flip = 1; end
    else if (r < -HalfPi30) begin r += Pi30; flip = 1; end
    for (int i = 0; i < Steps && i < 32; i++) begin
      if (r >= 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); r -= atan_step(i);
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); r += atan_step(i);
      end
      x = xn;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint mq(longint a, longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic rec_t mk(logic [1:0] k, longint a, longint b, longint c, longint d,
                              longint e, longint f, logic l);
    rec_t r;
    r.kind = k; r.fx = clip(a); r.fy = clip(b); r.sx = clip(c); r.sy = clip(d);
    r.ex = clip(e); r.ey = clip(f); r.last = l;
    return r;
  endfunction

  // append one record word to the expected queue
  task automatic queue_rec(rec_t r);
    expected_recs.insert(expected_recs.size(), r);
  endtask

  // predict the path records of one arc word
  task automatic predict_records(arc_t w);
    longint pcx, pcy, rx, ry, a0, sweep, mag, segs, delta, ts, tc, t, sa, ca, sn, cn, an;
    pcx = longint'(w.cx) + off_x;
    pcy = longint'(w.cy) + off_y;
    rx = w.rx; ry = w.ry; a0 = w.a0;
    sweep = longint'(w.a1) - a0;
    mag = sweep < 0 ? -sweep : sweep;
    if (mag >= TwoPi24 - Eps24) begin
      queue_rec(mk(KindFull, pcx, pcy, rx, ry, 0, 0, 1'b1));
      return;
    end
    if (!w.ccw && sweep < 0) sweep += TwoPi24;
    if (w.ccw && sweep > 0) sweep -= TwoPi24;
    if (sweep > TwoPi24) sweep = TwoPi24;
    if (sweep < -TwoPi24) sweep = -TwoPi24;
    mag = sweep < 0 ? -sweep : sweep;
    segs = (mag + HalfPi24 - 1) / HalfPi24;
    if (segs < 1) segs = 1;
    if (segs > 4) segs = 4;
    delta = sweep / segs;
    rotate(delta * 16, ts, tc);
    if (tc <= 0) tc = 1;
    t = (ts * 4 * (longint'(1) << 30)) / (tc * 3);
    rotate(a0 * 64, sa, ca);
    queue_rec(mk(w.empty ? KindMove : KindLine, pcx + mq(rx, ca),
                 pcy + mq(ry, sa), 0, 0, 0, 0, 1'b0));
    for (int k = 0; k < segs; k++) begin
      an = a0 + longint'(k + 1) * delta;
      rotate(an * 64, sn, cn);
      queue_rec(mk(KindCubic,
        pcx + mq(rx, ca) - mq(mq(rx, sa), t), pcy + mq(ry, sa) + mq(mq(ry, ca), t),
        pcx + mq(rx, cn) + mq(mq(rx, sn), t), pcy + mq(ry, sn) - mq(mq(ry, cn), t),
        pcx + mq(rx, cn), pcy + mq(ry, sn), (k + 1 == segs)));
      sa = sn; ca = cn;
    end
  endtask

  // driver: one word from the queue per handshake, random gap before each
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_records(pending_arcs.pop_front());
      gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      in_valid_i <= 1'b0;
    end else if (!in_valid_i && rst_ni && !driver_paused && pending_arcs.size() > 0) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else begin
        in_valid_i <= 1'b1;
        center_x_i <= pending_arcs[0].cx; center_y_i <= pending_arcs[0].cy;
        radius_x_i <= pending_arcs[0].rx; radius_y_i <= pending_arcs[0].ry;
        start_angle_i <= pending_arcs[0].a0; end_angle_i <= pending_arcs[0].a1;
        counter_clockwise_i <= pending_arcs[0].ccw; path_empty_i <= pending_arcs[0].empty;
      end
    end
  end

  // monitor: compare each accepted record, then draw the next stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    rec_t got, exp_rec;
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      got = '{record_kind_o, first_x_o, first_y_o, second_x_o, second_y_o,
              end_x_o, end_y_o, last_record_o};
      if (expected_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record kind %0d", got.kind);
      end else begin
        exp_rec = expected_recs.pop_front();
        if (got != exp_rec) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: k%0d %0d %0d %0d %0d %0d %0d l%0d",
              exp_rec.kind, exp_rec.fx, exp_rec.fy, exp_rec.sx, exp_rec.sy,
              exp_rec.ex, exp_rec.ey, exp_rec.last);
            $display("         got: k%0d %0d %0d %0d %0d %0d %0d l%0d",
              got.kind, got.fx, got.fy, got.sx, got.sy, got.ex, got.ey, got.last);
          end
        end
      end
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    end else if (hold_off) out_ready_i <= 1'b0;
    else if (stall_left > 0) stall_left <= stall_left - 1;
    else out_ready_i <= rst_ni;
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > MaxCycles) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_angle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * 105414357)) - 105414357;
      2: return $signed($urandom_range(0, 8 * 105414357)) - 4 * 105414357;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
  endfunction

  task automatic add_arc(logic signed [31:0] cx, cy, rx, ry, a0, a1, logic ccw, empty);
    arc_t w;
    w = '{cx, cy, rx, ry, a0, a1, ccw, empty};
    pending_arcs.insert(pending_arcs.size(), w);
  endtask

  task automatic add_random(int n);
    logic signed [31:0] a0;
    for (int i = 0; i < n; i++) begin
      a0 = rnd_angle();
      add_arc(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), a0,
              $urandom_range(0, 1) ? rnd_angle() : a0 + ($signed($urandom_range(0, 40)) - 20),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // wait until everything sent has come back, then let the block settle
  task automatic drain();
    while (pending_arcs.size() > 0 || in_valid_i || expected_recs.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_offsets(logic [31:0] x, logic [31:0] y);
    cfg_we_i <= 1'b1; cfg_index_i <= CfgOffsetX; cfg_wdata_i <= x;
    @(posedge clk_i);
    cfg_index_i <= CfgOffsetY; cfg_wdata_i <= y;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    off_x = $signed(x);
    off_y = $signed(y);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full turn edges, zero sweep, wraps, extremes, both start kinds
    add_arc(0, 0, 32'sh10000, 32'sh20000, 0, 105414357, 1'b0, 1'b1);
    add_arc(0, 0, 32'sh10000, 32'sh10000, 0, 105414357 - 16777, 1'b1, 1'b0);
    add_arc(0, 0, 32'sh10000, 32'sh10000, 0, 105414357 - 16778, 1'b0, 1'b1);
    add_arc(5, 7, 32'sh10000, 32'sh10000, 1000, 1000, 1'b0, 1'b1);
    add_arc(5, 7, 32'sh10000, 32'sh10000, 1000, 1000, 1'b1, 1'b0);
    add_arc(0, 0, 32'sh30000, 32'sh10000, 0, 26353589, 1'b0, 1'b1);
    add_arc(0, 0, 32'sh30000, 32'sh10000, 0, 26353590, 1'b0, 1'b0);
    add_arc(0, 0, 32'sh30000, 32'sh10000, 0, 52707178, 1'b1, 1'b1);
    add_arc(0, 0, 32'sh30000, 32'sh10000, 26353589, 0, 1'b0, 1'b1);
    add_arc(0, 0, 32'sh30000, 32'sh10000, 26353589, 0, 1'b1, 1'b0);
    add_arc(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
            32'sh80000000, 32'sh7FFFFFFF, 1'b0, 1'b1);
    add_arc(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1, 1'b1, 1'b0);
    add_arc(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 79060767,
            1'b0, 1'b1);
    add_arc(-32'sh10000, 32'sh10000, -32'sh40000, 32'sh40000, 32'sh7FFFFFFF,
            32'sh7FFF0000, 1'b0, 1'b0);
    add_arc(0, 0, 32'sh10000, 32'sh10000, -200000000, -190000000, 1'b1, 1'b1);
    add_arc(-1, -1, -1, -1, 32'sh80000000, 32'sh80000001, 1'b1, 1'b0);
    drain();

    // receiver holds off long while the sender keeps offering words
    write_offsets(32'h7FFFFFFF, 32'h80000000);
    hold_off = 1'b1;
    add_random(8);
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
    drain();

    write_offsets(32'h80000000, 32'h7FFFFFFF);
    add_random(120);
    drain();

    // sender pauses mid-stream until all records are back
    add_random(20);
    repeat (2000) @(posedge clk_i);
    driver_paused = 1'b1;
    while (in_valid_i || expected_recs.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    driver_paused = 1'b0;
    drain();

    write_offsets($urandom, $urandom);
    add_random(130);
    drain();

    write_offsets(0, 0);
    add_random(120);
    drain();

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

[elliptic_arc_to_cubic_bezier.f]
+incdir+design
design/eacb_pkg.sv
design/eacb_cordic.sv
design/eacb_div.sv
design/eacb_dp.sv
design/eacb_ctrl.sv
design/elliptic_arc_to_cubic_bezier.sv
design/eacb_checker.sv
tb/elliptic_arc_to_cubic_bezier_tb.sv
